/* design/rfcs_pkg.sv */
// Shared types, widths and constants of the cosine and sine feature pipeline.
package rfcs_pkg;

  // Number of rotation cells in the chain (valid range 12 to 32).
  localparam int unsigned CORDIC_STAGES = 24;

  localparam int unsigned XW = 33;  // width of the rotator x and y words
  localparam int unsigned ZW = 34;  // width of the residual phase word
  localparam int unsigned SW = 5;   // width of a cell's stage index

  // One turn is 2^32; TURN_K is 1/(2 pi) as a Q0.64 fraction.
  localparam logic [31:0] TURN_K_HI = 32'h28BE_60DB;
  localparam logic [31:0] TURN_K_LO = 32'h9391_054A;

  // Gain compensation of the rotator in Q2.30.
  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } rfcs_quad_e;

  // Item travelling along the rotator chain.
  typedef struct packed {
    logic                   valid;
    rfcs_quad_e             quad;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } rfcs_rot_t;

  // atan(2^-i) / (2 pi) as a Q0.32 fraction of a turn, rounded.
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

endpackage

/* design/rfcs_phase.sv */
// Front end: angle product, reduction to a fraction of a turn, quadrant split.
module rfcs_phase import rfcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] x_value_i,
  input  logic [31:0] chi_scale_i,
  output rfcs_rot_t   rot_o
);

  // Stage 1: exact angle magnitude |x| * chi.
  logic        v1_q;
  logic        neg1_q;
  logic [63:0] ang_q;
  // Stage 2: partial products of angle * TURN_K.
  logic        v2_q;
  logic        neg2_q;
  logic [63:0] pp_ll_q, pp_hl_q, pp_lh_q, pp_hh_q;
  // Stage 3: phase in turns.
  logic        v3_q;
  logic        neg3_q;
  logic [31:0] phase_q;
  // Stage 4: quadrant and residual.
  logic        v4_q;
  rfcs_quad_e  quad_q;
  logic [ZW-1:0] z_q;

  logic [31:0] mag;
  logic [33:0] mid_sum;
  logic [31:0] phase_d;
  logic [31:0] phase_s;
  logic [31:0] bias_sum;
  logic [31:0] resid;

  // The most negative value maps to 2^31, which still fits 32 unsigned bits.
  assign mag = x_value_i[31] ? (32'd0 - x_value_i) : x_value_i;

  assign mid_sum = {2'b00, pp_ll_q[63:32]} + {2'b00, pp_hl_q[31:0]}
                 + {2'b00, pp_lh_q[31:0]};
  assign phase_d = pp_hh_q[31:0] + pp_hl_q[63:32] + pp_lh_q[63:32]
                 + {30'd0, mid_sum[33:32]};

  assign phase_s  = neg3_q ? (32'd0 - phase_q) : phase_q;
  assign bias_sum = phase_s + 32'h2000_0000;
  assign resid    = phase_s - {bias_sum[31:30], 30'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= x_value_i[31];
      ang_q   <= 64'(mag) * 64'(chi_scale_i);
      neg2_q  <= neg1_q;
      pp_ll_q <= 64'(ang_q[31:0])  * 64'(TURN_K_LO);
      pp_hl_q <= 64'(ang_q[63:32]) * 64'(TURN_K_LO);
      pp_lh_q <= 64'(ang_q[31:0])  * 64'(TURN_K_HI);
      pp_hh_q <= 64'(ang_q[63:32]) * 64'(TURN_K_HI);
      neg3_q  <= neg2_q;
      phase_q <= phase_d;
      quad_q  <= rfcs_quad_e'(bias_sum[31:30]);
      z_q     <= ZW'($signed(resid));
    end
  end

  assign rot_o.valid = v4_q;
  assign rot_o.quad  = quad_q;
  assign rot_o.x     = CORDIC_GAIN;
  assign rot_o.y     = '0;
  assign rot_o.z     = $signed(z_q);

endmodule

/* design/rfcs_cell.sv */
// One rotation cell of the CORDIC chain.
module rfcs_cell import rfcs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [SW-1:0] stage_i,
  input  rfcs_rot_t     rot_i,
  output rfcs_rot_t     rot_o
);

  logic       valid_q;
  rfcs_rot_t  data_q;
  rfcs_rot_t  data_d;

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] ang;

  assign dx  = rot_i.y >>> stage_i;
  assign dy  = rot_i.x >>> stage_i;
  assign ang = $signed({{(ZW-32){1'b0}}, ATAN_TURNS[stage_i]});

  always_comb begin
    data_d       = rot_i;
    data_d.valid = 1'b0;
    if (!rot_i.z[ZW-1]) begin
      data_d.x = rot_i.x - dx;
      data_d.y = rot_i.y + dy;
      data_d.z = rot_i.z - ang;
    end else begin
      data_d.x = rot_i.x + dx;
      data_d.y = rot_i.y - dy;
      data_d.z = rot_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= rot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    rot_o       = data_q;
    rot_o.valid = valid_q;
  end

endmodule

/* design/rfcs_scale.sv */
// Back end: quadrant fix-up, normalization product, rounding and saturation.
module rfcs_scale import rfcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [31:0] norm_i,
  input  rfcs_rot_t   rot_i,
  output logic        valid_o,
  output logic [31:0] cos_o,
  output logic [31:0] sin_o
);

  logic               v1_q, v2_q, v3_q;
  logic signed [31:0] c_q, s_q;
  logic signed [65:0] pc_q, ps_q;
  logic [31:0]        cos_q, sin_q;

  logic signed [31:0] cx, cy, c_d, s_d;

  assign cx = 32'(rot_i.x);
  assign cy = 32'(rot_i.y);

  always_comb begin
    unique case (rot_i.quad)
      QUAD_0:   begin c_d = cx;           s_d = cy;           end
      QUAD_90:  begin c_d = 32'sd0 - cy;  s_d = cx;           end
      QUAD_180: begin c_d = 32'sd0 - cx;  s_d = 32'sd0 - cy;  end
      default:  begin c_d = cy;           s_d = 32'sd0 - cx;  end
    endcase
  end

  // Round half up at bit 30, then clamp to the signed 32-bit range.
  function automatic logic [31:0] round_sat(input logic signed [65:0] p);
    logic signed [65:0] r;
    r = (p + 66'sd536870912) >>> 30;
    if (r > 66'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (r < -66'sd2147483648) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= rot_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= c_d;
      s_q   <= s_d;
      pc_q  <= 66'($signed({1'b0, norm_i})) * 66'(c_q);
      ps_q  <= 66'($signed({1'b0, norm_i})) * 66'(s_q);
      cos_q <= round_sat(pc_q);
      sin_q <= round_sat(ps_q);
    end
  end

  assign valid_o = v3_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

/* design/random_feature_cos_sin_top.sv */
// Top level of the random Fourier feature cosine and sine pipeline.
//
// Each input item carries a signed Q16.16 feature value (tdata bits 31:0) and an
// unsigned Q16.16 chi scale (bits 63:32). The block forms the angle as their
// product, reduces it to a fraction of a turn, rotates a unit vector through a
// chain of CORDIC_STAGES rotation cells and returns norm_scale times the cosine
// (tdata bits 31:0) and the sine (bits 63:32) as signed Q2.30 values, rounded
// half up and saturated. The block takes one item every cycle while the skid
// register is empty; the rate is set by the fully pipelined cell chain, in which
// every cell hands its item to the next one each clock while the pipeline is
// enabled. An item passes through CORDIC_STAGES + 8 registers: four front-end
// stages (angle product, turn product, phase sum, quadrant split), the cells,
// three back-end stages and the output register. A skid register behind the
// pipeline lets the input keep taking items while a result waits; the input
// stalls only once that skid holds an item. norm_scale resets to 1.0 and is
// written through cfg_we_i and cfg_wdata_i; the user must write it only while
// no item is in flight, and the block itself does not enforce this.
module random_feature_cos_sin_top import rfcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] x_value, [63:32] chi_scale
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] cos_feature, [63:32] sin_feature
);

  logic [31:0] norm_q;

  // The whole pipeline advances unless the skid register is occupied.
  logic pipe_en;

  rfcs_rot_t rot [CORDIC_STAGES+1];

  logic        pipe_valid;
  logic [31:0] pipe_cos, pipe_sin;

  logic        out_valid_q, skid_valid_q;
  logic [63:0] out_data_q, skid_data_q;
  logic        out_ready;

  assign pipe_en       = !skid_valid_q;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= 32'h4000_0000;
    end else if (cfg_we_i) begin
      norm_q <= cfg_wdata_i;
    end
  end

  rfcs_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (s_axis_tvalid),
    .x_value_i   (s_axis_tdata[31:0]),
    .chi_scale_i (s_axis_tdata[63:32]),
    .rot_o       (rot[0])
  );

  // The chain of rotation cells; each cell gets its own stage index.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rfcs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .stage_i (SW'(g)),
      .rot_i   (rot[g]),
      .rot_o   (rot[g+1])
    );
  end

  rfcs_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .norm_i  (norm_q),
    .rot_i   (rot[CORDIC_STAGES]),
    .valid_o (pipe_valid),
    .cos_o   (pipe_cos),
    .sin_o   (pipe_sin)
  );

  // Output register with a skid register behind it. A pipeline item moves on
  // whenever the pipeline is enabled: into the output register when that is
  // free or being emptied, otherwise into the skid register.
  assign out_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= pipe_valid;
      end
    end else if (pipe_valid && pipe_en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_data_q <= skid_valid_q ? skid_data_q : {pipe_sin, pipe_cos};
    end else if (pipe_en) begin
      skid_data_q <= {pipe_sin, pipe_cos};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The skid register only holds an item while the output register holds one.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the output register is empty");

  // The skid register fills only when the output was stalled.
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid register filled without an output stall");

  // A finished pipeline item waiting behind a full skid is not dropped.
  a_pipe_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_valid && skid_valid_q) |=> pipe_valid)
    else $error("pipeline item lost while the pipeline was stalled");

endmodule
